// ===== src/sccd_pkg.sv =====
// Package with shared types and constants of the sync/count/checksum deframer.
package sccd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_BYTE  = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] SYNC_RESET = 8'hAA;
    localparam logic [7:0] MAXLEN_RESET = 8'd128;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_HDR,
        S_SUM,
        S_OUT,
        S_EMIT
    } t_state;

endpackage

// ===== src/sccd_ram.sv =====
// Generic single-port RAM with registered read data.
module sccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write when enabled, read always.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== src/sync_count_checksum_deframer.sv =====
// Top level of the sync/count/checksum deframer with its byte sequencer.
// A byte is written into the hold buffer, then the sequencer reads held bytes
// one at a time through the single RAM port, issuing each read and checking the
// data it returns: scan, header, checksum pass and output pass, then words out.
// A request is taken only in idle, so no new byte is accepted until the sequencer
// has finished with the held bytes and returned to idle.
// Reset (synchronous, active low) empties the hold buffer and restores the configuration registers.
module sync_count_checksum_deframer
    import sccd_pkg::*;
#(
    parameter int BUF_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_data_word,
    output logic [3:0]  o_byte_count,
    output logic        o_frame_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);
    localparam logic [FW:0] DEPTH_W = (FW + 1)'(BUF_DEPTH);

    t_state r_state, n_state;
    logic [AW-1:0] r_start, n_start;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_idx, n_idx;
    logic r_wait, n_wait;
    logic [7:0] r_cnt, n_cnt;
    logic [15:0] r_sum, n_sum;
    logic [2:0] r_k, n_k;
    logic [63:0] r_word, n_word;
    logic [3:0] r_bcnt, n_bcnt;
    logic r_last, n_last;
    logic [7:0] r_sync, r_maxlen;

    logic ram_we;
    logic [FW-1:0] off;
    logic [FW:0] addr_sum, addr_wrap;
    logic [7:0] rd;
    logic drop_en;
    logic [FW-1:0] drop_n;
    logic [FW:0] drop_sum, drop_wrap;
    logic [FW-1:0] cnt_w, end_idx, size_w;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_maxlen <= MAXLEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_BYTE: r_sync <= i_cfg_data;
                CFG_MAX_LENGTH: r_maxlen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Circular address of the held byte at offset off.
    assign addr_sum = (FW + 1)'(r_start) + (FW + 1)'(off);
    assign addr_wrap = (addr_sum >= DEPTH_W) ? addr_sum - DEPTH_W : addr_sum;

    sccd_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (addr_wrap[AW-1:0]),
        .i_wdata(i_rx_byte),
        .o_rdata(rd)
    );

    // Frame geometry derived from the count byte.
    assign cnt_w = FW'(r_cnt);
    assign end_idx = cnt_w + FW'(3);
    assign size_w = (r_cnt == 8'd1) ? FW'(6) : cnt_w + FW'(6);

    // Start advance for dropping bytes off the front.
    assign drop_sum = (FW + 1)'(r_start) + (FW + 1)'(drop_n);
    assign drop_wrap = (drop_sum >= DEPTH_W) ? drop_sum - DEPTH_W : drop_sum;

    assign o_rx_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_data_word = r_word;
    assign o_byte_count = r_bcnt;
    assign o_frame_last = r_last;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_fill <= '0;
            r_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_fill <= n_fill;
            r_wait <= n_wait;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_sum <= n_sum;
        r_k <= n_k;
        r_word <= n_word;
        r_bcnt <= n_bcnt;
        r_last <= n_last;
    end

    // Sequencer: one RAM read issued, then checked in the next cycle.
    always_comb begin
        n_state = r_state;
        n_start = r_start;
        n_fill = r_fill;
        n_idx = r_idx;
        n_wait = r_wait;
        n_cnt = r_cnt;
        n_sum = r_sum;
        n_k = r_k;
        n_word = r_word;
        n_bcnt = r_bcnt;
        n_last = r_last;
        ram_we = 1'b0;
        off = r_idx;
        drop_en = 1'b0;
        drop_n = '0;
        case (r_state)
            S_IDLE: begin
                off = r_fill;
                if (i_rx_valid) begin
                    if ((FW + 1)'(r_fill) < DEPTH_W) begin
                        ram_we = 1'b1;
                        n_fill = r_fill + FW'(1);
                    end
                    n_state = S_FIND;
                    n_idx = '0;
                    n_wait = 1'b0;
                end
            end
            S_FIND: begin
                if (!r_wait) begin
                    if (r_idx >= r_fill) begin
                        n_start = '0;
                        n_fill = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_wait = 1'b1;
                    end
                end else begin
                    n_wait = 1'b0;
                    if (rd == r_sync) begin
                        drop_en = 1'b1;
                        drop_n = r_idx;
                        if ((r_fill - r_idx) < FW'(4)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = FW'(1);
                            n_state = S_HDR;
                        end
                    end else begin
                        n_idx = r_idx + FW'(1);
                    end
                end
            end
            S_HDR: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    if (r_idx < FW'(3)) begin
                        if (rd != r_sync) begin
                            drop_en = 1'b1;
                            drop_n = FW'(1);
                            n_idx = '0;
                            n_state = S_FIND;
                        end else begin
                            n_idx = r_idx + FW'(1);
                        end
                    end else if (rd == 8'd0 || rd > r_maxlen) begin
                        drop_en = 1'b1;
                        drop_n = FW'(1);
                        n_idx = '0;
                        n_state = S_FIND;
                    end else begin
                        n_cnt = rd;
                        n_sum = '0;
                        n_idx = FW'(4);
                        if (r_fill < ((rd == 8'd1) ? FW'(6) : FW'(rd) + FW'(6))) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SUM;
                        end
                    end
                end
            end
            S_SUM: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    if (r_idx <= end_idx) begin
                        n_sum = r_sum + 16'(rd);
                        n_idx = r_idx + FW'(1);
                    end else if (r_idx == end_idx + FW'(1)) begin
                        if (rd != r_sum[7:0]) begin
                            drop_en = 1'b1;
                            drop_n = FW'(1);
                            n_idx = '0;
                            n_state = S_FIND;
                        end else if (r_cnt == 8'd1) begin
                            n_idx = FW'(4);
                            n_k = '0;
                            n_word = '0;
                            n_state = S_OUT;
                        end else begin
                            n_idx = r_idx + FW'(1);
                        end
                    end else begin
                        if (rd != r_sum[15:8]) begin
                            drop_en = 1'b1;
                            drop_n = FW'(1);
                            n_idx = '0;
                            n_state = S_FIND;
                        end else begin
                            n_idx = FW'(4);
                            n_k = '0;
                            n_word = '0;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_OUT: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    for (int b = 0; b < 8; b++) begin
                        if (r_k == 3'(b)) begin
                            n_word[b*8 +: 8] = rd;
                        end
                    end
                    n_idx = r_idx + FW'(1);
                    if (r_k == 3'd7 || r_idx == end_idx) begin
                        n_last = (r_idx == end_idx);
                        n_bcnt = 4'(r_k) + 4'd1;
                        n_state = S_EMIT;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (r_last) begin
                        drop_en = 1'b1;
                        drop_n = size_w;
                        n_idx = '0;
                        n_state = S_FIND;
                    end else begin
                        n_k = '0;
                        n_word = '0;
                        n_state = S_OUT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Remove bytes from the front of the hold buffer.
        if (drop_en) begin
            if (drop_n >= r_fill) begin
                n_start = '0;
                n_fill = '0;
            end else begin
                n_start = drop_wrap[AW-1:0];
                n_fill = r_fill - drop_n;
            end
        end
    end

    // The fill count never exceeds the buffer depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FW + 1)'(r_fill) <= DEPTH_W)
        else $error("hold fill beyond buffer depth");

    // The start index always addresses a real entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW + 1)'(r_start) < (AW + 1)'(BUF_DEPTH))
        else $error("hold start out of range");

    // A presented word holds one to eight bytes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_count != 4'd0 && o_byte_count <= 4'd8))
        else $error("bad byte count on output");

endmodule
